>>> hdl/xcfr_pkg.sv
// Shared types and constants for the XOR checksum frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package xcfr_pkg;

   localparam int LEN_W  = 7;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 6;

   localparam logic [BYTE_W-1:0] SYNC_A = 8'h06;
   localparam logic [BYTE_W-1:0] SYNC_B = 8'h85;

   typedef enum logic [2:0] {
      ST_CHANGED    = 3'd0,
      ST_UNCHANGED  = 3'd1,
      ST_LENGTH     = 3'd2,
      ST_CHECKSUM   = 3'd3,
      ST_INCOMPLETE = 3'd4
   } status_type;

endpackage

`default_nettype wire

>>> hdl/xcfr_cmd_queue.sv
// Two-entry command queue between the frame parser and the result sequencer.
// Depends on xcfr_pkg for the status type.
`default_nettype none

module xcfr_cmd_queue import xcfr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire status_type push_status,
   output logic            full,
   input  wire logic       pop,
   output status_type      pop_status,
   output logic            empty
);

   status_type  slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign empty      = (count_ff == 2'd0);
   assign pop_status = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/xcfr_store.sv
// Frame buffer and mirrored payload copy, both with registered reads.
// The mirror reads as zero until an entry is written. Depends on xcfr_pkg.
`default_nettype none

module xcfr_store import xcfr_pkg::*; #(
   parameter int MAX_PAYLOAD = 64,
   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // frame buffer write (parser) and read (sequencer)
   input  wire logic              fw_en,
   input  wire logic [AW-1:0]     fw_addr,
   input  wire logic [BYTE_W-1:0] fw_data,
   input  wire logic              fr_en,
   input  wire logic [AW-1:0]     fr_addr,
   output logic [BYTE_W-1:0]      fr_data,
   // mirror read (parser) and write (sequencer)
   input  wire logic              mr_en,
   input  wire logic [AW-1:0]     mr_addr,
   output logic [BYTE_W-1:0]      mr_data,
   input  wire logic              mw_en,
   input  wire logic [AW-1:0]     mw_addr,
   input  wire logic [BYTE_W-1:0] mw_data
);

   logic [BYTE_W-1:0]      frame_mem [MAX_PAYLOAD];
   logic [BYTE_W-1:0]      mirror_mem [MAX_PAYLOAD];
   logic [MAX_PAYLOAD-1:0] mirror_vld_ff;
   logic [BYTE_W-1:0]      fr_data_ff;
   logic [BYTE_W-1:0]      mr_raw_ff;
   logic                   mr_vld_ff;

   assign fr_data = fr_data_ff;
   assign mr_data = mr_vld_ff ? mr_raw_ff : '0;

   always_ff @(posedge clock) begin
      if (fw_en) begin
         frame_mem[fw_addr] <= fw_data;
      end
      if (fr_en) begin
         fr_data_ff <= frame_mem[fr_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mw_en) begin
         mirror_mem[mw_addr] <= mw_data;
      end
      if (mr_en) begin
         mr_raw_ff <= mirror_mem[mr_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_vld_ff <= '0;
         mr_vld_ff     <= 1'b0;
      end else begin
         if (mw_en) begin
            mirror_vld_ff[mw_addr] <= 1'b1;
         end
         if (mr_en) begin
            mr_vld_ff <= mirror_vld_ff[mr_addr];
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/xcfr_front.sv
// Frame parser: hunts for the header, checks length, collects the payload
// and checksum, and queues one command per frame. Depends on xcfr_pkg.
`default_nettype none

module xcfr_front import xcfr_pkg::*; #(
   parameter int MAX_PAYLOAD = 64,
   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   input  wire logic              req_transfer_end,
   input  wire logic [LEN_W-1:0]  payload_len,
   // command queue
   input  wire logic              q_full,
   output logic                   q_push,
   output status_type             q_status,
   // sequencer finished copying the frame into the mirror
   input  wire logic              copy_done,
   // memories
   output logic                   fw_en,
   output logic [AW-1:0]          fw_addr,
   output logic [BYTE_W-1:0]      fw_data,
   output logic                   mr_en,
   output logic [AW-1:0]          mr_addr,
   input  wire logic [BYTE_W-1:0] mr_data
);

   typedef enum logic [5:0] {
      PH_HUNT    = 6'b000001,
      PH_HDR2    = 6'b000010,
      PH_LEN     = 6'b000100,
      PH_PAYLOAD = 6'b001000,
      PH_CKSUM   = 6'b010000,
      PH_DISCARD = 6'b100000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic              differs_ff, differs_in;
   logic              cmp_pend_ff, cmp_pend_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              copy_busy_ff, copy_busy_in;

   logic              accept;
   logic              len_ok;
   logic              differs_now;
   logic              frame_done;
   logic              open_frame;
   logic [LEN_W-1:0]  count_inc;

   // no new bytes while the sequencer owns both memories
   assign req_full = q_full || copy_busy_ff;
   assign accept   = req_push && !req_full;

   assign len_ok = ({1'b0, payload_len} == req_rx_byte) &&
                   (int'(payload_len) <= MAX_PAYLOAD);

   // mirror data for the previous payload byte lands in the cycle after its read
   assign differs_now = differs_ff || (cmp_pend_ff && (mr_data != byte_ff));

   assign count_inc = count_ff + 7'd1;
   assign fw_addr   = AW'(count_ff);
   assign mr_addr   = AW'(count_ff);
   assign fw_data   = req_rx_byte;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      xor_in       = xor_ff;
      differs_in   = differs_now;
      cmp_pend_in  = 1'b0;
      byte_in      = byte_ff;
      copy_busy_in = copy_busy_ff && !copy_done;
      q_push       = 1'b0;
      q_status     = ST_INCOMPLETE;
      fw_en        = 1'b0;
      mr_en        = 1'b0;
      frame_done   = 1'b0;
      open_frame   = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               open_frame = 1'b1;
               if (req_rx_byte == SYNC_A) begin
                  phase_in = PH_HDR2;
               end
            end
            PH_HDR2: begin
               open_frame = 1'b1;
               if (req_rx_byte == SYNC_B) begin
                  phase_in = PH_LEN;
               end else if (req_rx_byte == SYNC_A) begin
                  phase_in = PH_HDR2;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_LEN: begin
               if (!len_ok) begin
                  q_push     = 1'b1;
                  q_status   = ST_LENGTH;
                  frame_done = 1'b1;
               end else begin
                  open_frame = 1'b1;
                  xor_in     = req_rx_byte;
                  count_in   = '0;
                  differs_in = 1'b0;
                  phase_in   = (payload_len == '0) ? PH_CKSUM : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               open_frame  = 1'b1;
               fw_en       = 1'b1;
               mr_en       = 1'b1;
               byte_in     = req_rx_byte;
               cmp_pend_in = 1'b1;
               xor_in      = xor_ff ^ req_rx_byte;
               count_in    = count_inc;
               if (count_inc >= payload_len) begin
                  phase_in = PH_CKSUM;
               end
            end
            PH_CKSUM: begin
               frame_done = 1'b1;
               q_push     = 1'b1;
               if (xor_ff != req_rx_byte) begin
                  q_status = ST_CHECKSUM;
               end else if (!differs_now || payload_len == '0) begin
                  q_status = ST_UNCHANGED;
               end else begin
                  q_status     = ST_CHANGED;
                  copy_busy_in = 1'b1;
               end
            end
            PH_DISCARD: begin
               if (req_transfer_end) begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase

         if (frame_done) begin
            phase_in = req_transfer_end ? PH_HUNT : PH_DISCARD;
         end else if (open_frame && req_transfer_end) begin
            q_push   = 1'b1;
            q_status = ST_INCOMPLETE;
            phase_in = PH_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         xor_ff       <= '0;
         differs_ff   <= 1'b0;
         cmp_pend_ff  <= 1'b0;
         copy_busy_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         differs_ff   <= differs_in;
         cmp_pend_ff  <= cmp_pend_in;
         copy_busy_ff <= copy_busy_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/xcfr_back.sv
// Result sequencer: turns queued commands into result items, copying the
// frame buffer into the mirror on a changed frame. Depends on xcfr_pkg.
`default_nettype none

module xcfr_back import xcfr_pkg::*; #(
   parameter int MAX_PAYLOAD = 64,
   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [LEN_W-1:0]  payload_len,
   // command queue
   input  wire logic              q_empty,
   input  wire status_type        q_status,
   output logic                   q_pop,
   // memories
   output logic                   fr_en,
   output logic [AW-1:0]          fr_addr,
   input  wire logic [BYTE_W-1:0] fr_data,
   output logic                   mw_en,
   output logic [AW-1:0]          mw_addr,
   output logic [BYTE_W-1:0]      mw_data,
   output logic                   copy_done,
   // result channel
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output status_type             rsp_status,
   output logic [BYTE_W-1:0]      rsp_data_byte,
   output logic [IDX_W-1:0]       rsp_byte_index,
   output logic                   rsp_last
);

   typedef enum logic [1:0] {
      B_IDLE  = 2'b01,
      B_FETCH = 2'b10
   } seq_type;

   seq_type           state_ff, state_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic              out_vld_ff, out_vld_in;
   status_type        out_status_ff, out_status_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic [IDX_W-1:0]  out_index_ff, out_index_in;
   logic              out_last_ff, out_last_in;

   logic              out_free;
   logic              last_byte;
   logic [LEN_W-1:0]  idx_inc;

   assign out_free  = !out_vld_ff || rsp_pop;
   assign idx_inc   = idx_ff + 7'd1;
   assign last_byte = (idx_inc == payload_len);

   assign mw_addr = AW'(idx_ff);
   assign mw_data = fr_data;

   assign rsp_empty      = !out_vld_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_data_byte  = out_data_ff;
   assign rsp_byte_index = out_index_ff;
   assign rsp_last       = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      q_pop         = 1'b0;
      fr_en         = 1'b0;
      fr_addr       = AW'(idx_ff);
      mw_en         = 1'b0;
      copy_done     = 1'b0;
      out_vld_in    = out_vld_ff && !rsp_pop;
      out_status_in = out_status_ff;
      out_data_in   = out_data_ff;
      out_index_in  = out_index_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               if (q_status == ST_CHANGED) begin
                  fr_en    = 1'b1;
                  fr_addr  = '0;
                  idx_in   = '0;
                  state_in = B_FETCH;
               end else begin
                  out_vld_in    = 1'b1;
                  out_status_in = q_status;
                  out_data_in   = '0;
                  out_index_in  = '0;
                  out_last_in   = 1'b1;
               end
            end
         end
         B_FETCH: begin
            // frame byte for idx_ff is in the read register here
            if (out_free) begin
               out_vld_in    = 1'b1;
               out_status_in = ST_CHANGED;
               out_data_in   = fr_data;
               out_index_in  = idx_ff[IDX_W-1:0];
               out_last_in   = last_byte;
               mw_en         = 1'b1;
               if (last_byte) begin
                  copy_done = 1'b1;
                  state_in  = B_IDLE;
               end else begin
                  idx_in  = idx_inc;
                  fr_en   = 1'b1;
                  fr_addr = AW'(idx_inc);
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      out_status_ff <= out_status_in;
      out_data_ff   <= out_data_in;
      out_index_ff  <= out_index_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/xor_checksum_frame_receiver.sv
// Top level of the XOR checksum frame receiver: parser, command queue,
// memories, result sequencer and the payload length register.
// Depends on xcfr_pkg, xcfr_front, xcfr_cmd_queue, xcfr_store, xcfr_back.
// Usage:
//   req_ channel: push a received byte with its transfer_end flag; the byte
//   is taken when req_push is high and req_full is low. One byte per cycle.
//   rsp_ channel: a result waits on the rsp_ ports while rsp_empty is low and
//   is taken when rsp_pop is high.
//   csr_ channel: csr_ready is always high; write payload_len only while the
//   block is idle. It resets to 1.
// Results: a status result is queued and then registered at the rsp_ ports
//   after the byte that finishes the frame. A changed frame emits payload_len
//   results, one per cycle while rsp_pop stays high; after its checksum byte
//   it is queued, read from the frame buffer and then registered at rsp_.
// Throughput: one byte per cycle. While a changed frame is being copied
//   into the mirror and emitted, req_full stays high; the two-entry command
//   queue also raises it when the result side stalls long enough to fill it.
// Reset: the parser hunts for the sync byte, the mirror reads as all zero
//   and no results are pending. No clearing pass is needed.
`default_nettype none

module xor_checksum_frame_receiver import xcfr_pkg::*; #(
   parameter int MAX_PAYLOAD = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   input  wire logic              req_transfer_end,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output logic [2:0]             rsp_status,
   output logic [BYTE_W-1:0]      rsp_data_byte,
   output logic [IDX_W-1:0]       rsp_byte_index,
   output logic                   rsp_last,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [LEN_W-1:0]  csr_payload_len
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [LEN_W-1:0]  payload_len_ff;
   logic              q_push, q_full, q_pop, q_empty;
   status_type        q_push_status, q_pop_status;
   status_type        rsp_status_enum;
   logic              copy_done;
   logic              fw_en, mr_en, fr_en, mw_en;
   logic [AW-1:0]     fw_addr, mr_addr, fr_addr, mw_addr;
   logic [BYTE_W-1:0] fw_data, mr_data, fr_data, mw_data;

   assign csr_ready  = 1'b1;
   assign rsp_status = rsp_status_enum;

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_len_ff <= 7'd1;
      end else if (csr_valid && csr_ready) begin
         payload_len_ff <= csr_payload_len;
      end
   end

   xcfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_rx_byte      (req_rx_byte),
      .req_transfer_end (req_transfer_end),
      .payload_len      (payload_len_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_status         (q_push_status),
      .copy_done        (copy_done),
      .fw_en            (fw_en),
      .fw_addr          (fw_addr),
      .fw_data          (fw_data),
      .mr_en            (mr_en),
      .mr_addr          (mr_addr),
      .mr_data          (mr_data)
   );

   xcfr_cmd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_status (q_push_status),
      .full        (q_full),
      .pop         (q_pop),
      .pop_status  (q_pop_status),
      .empty       (q_empty)
   );

   xcfr_store #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_store (
      .clock   (clock),
      .reset   (reset),
      .fw_en   (fw_en),
      .fw_addr (fw_addr),
      .fw_data (fw_data),
      .fr_en   (fr_en),
      .fr_addr (fr_addr),
      .fr_data (fr_data),
      .mr_en   (mr_en),
      .mr_addr (mr_addr),
      .mr_data (mr_data),
      .mw_en   (mw_en),
      .mw_addr (mw_addr),
      .mw_data (mw_data)
   );

   xcfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock          (clock),
      .reset          (reset),
      .payload_len    (payload_len_ff),
      .q_empty        (q_empty),
      .q_status       (q_pop_status),
      .q_pop          (q_pop),
      .fr_en          (fr_en),
      .fr_addr        (fr_addr),
      .fr_data        (fr_data),
      .mw_en          (mw_en),
      .mw_addr        (mw_addr),
      .mw_data        (mw_data),
      .copy_done      (copy_done),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_status     (rsp_status_enum),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   // parser only queues a command when there is room
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command queue overflow");

   // sequencer only pops a queued command
   a_no_queue_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command queue underflow");

   // while the sequencer touches the memories the input side is held off
   a_copy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (fr_en || mw_en) |-> req_full)
      else $error("input accepted during mirror copy");

   // the last byte of a changed frame sits at payload_len - 1
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status_enum == ST_CHANGED && rsp_last) |->
      (rsp_byte_index == IDX_W'(payload_len_ff - 7'd1)))
      else $error("last payload byte at wrong index");
`endif

endmodule

`default_nettype wire
